[design/assert_macros.svh]
// Assertion macros used by the checker file of this project.
// The macros expect a signal named clk, and ASSERT_NEXT one named rst, in the scope where used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Next-cycle implication that is checked only outside reset.
`define ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");

// Next-cycle implication that is also checked while reset is applied.
`define ASSERT_NEXT_ALWAYS(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

[design/oets_pkg.sv]
// Types and constants for the odd-even transposition sorter.
// No dependencies; used by every module of the block.
`default_nettype none

package oets_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [31:0] in_value;
    logic               is_last;
  } item_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic               out_last;
    logic               overflow;
  } result_t;

  // Classified item handed from the front end to the sorting engine.
  typedef struct packed {
    logic signed [31:0] value;
    logic               keep;
    logic               is_last;
    logic               overflow;
  } cmd_t;

endpackage

`default_nettype wire

[design/oets_front.sv]
// Front end: accepts items and classifies each as stored or dropped.
// Depends on oets_pkg.
`default_nettype none

module oets_front #(
  parameter int DEPTH = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire oets_pkg::item_t item,
  input  wire logic           full,
  output logic                push,
  output oets_pkg::cmd_t      cmd
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          ovf;
  logic          ovf_next;
  logic          drop;

  assign push = start && !full;
  assign drop = (count == CW'(DEPTH));

  always_comb begin
    count_next = count;
    ovf_next   = ovf;
    if (push) begin
      if (drop) begin
        ovf_next = 1'b1;
      end else begin
        count_next = count + CW'(1);
      end
      // The batch closes here; the next item opens a new one.
      if (item.is_last) begin
        count_next = '0;
        ovf_next   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      count <= count_next;
      ovf   <= ovf_next;
    end
  end

  assign cmd.value    = item.in_value;
  assign cmd.keep     = !drop;
  assign cmd.is_last  = item.is_last;
  assign cmd.overflow = ovf || drop;

endmodule

`default_nettype wire

[design/oets_queue.sv]
// Two-entry queue of classified items between front end and sorting engine.
// Depends on oets_pkg.
`default_nettype none

module oets_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire oets_pkg::cmd_t wdata,
  input  wire logic          pop,
  output oets_pkg::cmd_t     rdata,
  output logic               full,
  output logic               empty
);

  oets_pkg::cmd_t                   entries [oets_pkg::QUEUE_DEPTH];
  logic [oets_pkg::QUEUE_AW-1:0]    wptr;
  logic [oets_pkg::QUEUE_AW-1:0]    rptr;
  logic [oets_pkg::QUEUE_CW-1:0]    cnt;
  logic [oets_pkg::QUEUE_CW-1:0]    cnt_next;

  assign full  = (cnt == oets_pkg::QUEUE_CW'(oets_pkg::QUEUE_DEPTH));
  assign empty = (cnt == '0);
  assign rdata = entries[rptr];

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) begin
      cnt_next = cnt + oets_pkg::QUEUE_CW'(1);
    end else if (pop && !push) begin
      cnt_next = cnt - oets_pkg::QUEUE_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + oets_pkg::QUEUE_AW'(1);
      end
      if (pop) begin
        rptr <= rptr + oets_pkg::QUEUE_AW'(1);
      end
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

[design/oets_back.sv]
// Sorting engine: a row of value cells that loads a batch, sorts it by
// parallel odd-even transposition phases and shifts the result out.
// Depends on oets_pkg.
`default_nettype none

module oets_back #(
  parameter int DEPTH = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire oets_pkg::cmd_t cmd,
  input  wire logic           empty,
  output logic                pop,
  output logic                valid,
  output oets_pkg::result_t   result
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_LOAD = 3'b001,
    S_SORT = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t             state;
  state_t             state_next;
  logic signed [31:0] cells      [DEPTH];
  logic signed [31:0] cells_next [DEPTH];
  logic [DEPTH-2:0]   swp;
  logic [CW-1:0]      fill;
  logic [CW-1:0]      fill_next;
  logic               odd_phase;
  logic               odd_phase_next;
  logic               ovf;
  logic               ovf_next;

  assign pop = (state == S_LOAD) && !empty;

  // A pair takes part when its left index matches the phase parity and both
  // of its entries lie inside the batch.
  always_comb begin
    for (int i = 0; i < DEPTH - 1; i++) begin
      swp[i] = (state == S_SORT) && (i[0] == odd_phase) && (CW'(i + 1) < fill) &&
               (cells[i] > cells[i + 1]);
    end
  end

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    odd_phase_next = odd_phase;
    ovf_next       = ovf;
    for (int i = 0; i < DEPTH; i++) begin
      cells_next[i] = cells[i];
    end
    unique case (state)
      S_LOAD: begin
        if (pop) begin
          if (cmd.keep) begin
            cells_next[fill[IW-1:0]] = cmd.value;
            fill_next = fill + CW'(1);
          end
          if (cmd.is_last) begin
            ovf_next       = cmd.overflow;
            odd_phase_next = 1'b0;
            state_next     = S_SORT;
          end
        end
      end
      S_SORT: begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          if (swp[i]) begin
            cells_next[i]     = cells[i + 1];
            cells_next[i + 1] = cells[i];
          end
        end
        // An odd phase without a swap follows an even phase, so all is in order.
        if (odd_phase && (swp == '0)) begin
          odd_phase_next = 1'b0;
          state_next     = S_EMIT;
        end else begin
          odd_phase_next = !odd_phase;
        end
      end
      S_EMIT: begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          cells_next[i] = cells[i + 1];
        end
        fill_next = fill - CW'(1);
        if (fill == CW'(1)) begin
          ovf_next   = 1'b0;
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      fill      <= '0;
      odd_phase <= 1'b0;
      ovf       <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      odd_phase <= odd_phase_next;
      ovf       <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      cells[i] <= cells_next[i];
    end
  end

  assign valid            = (state == S_EMIT);
  assign result.out_value = cells[0];
  assign result.out_last  = (fill == CW'(1));
  assign result.overflow  = ovf;

endmodule

`default_nettype wire

[design/odd_even_transposition_sorter_core.sv]
// Top level of the odd-even transposition sorter.
// Depends on oets_pkg, oets_front, oets_queue and oets_back.
//
// Items are taken one per cycle while busy is low. A batch of n stored
// values, closed by an item with is_last set, is loaded into the row of
// DEPTH value cells, sorted there by alternating even and odd phases of
// transposition until an odd phase makes no swap, then the sorted values
// leave one per cycle with valid high; the receiver cannot stall, so each
// result must be taken in its cycle. A two-entry queue lets the next batch
// start arriving while one is being sorted; busy rises once that queue is
// full.
`default_nettype none

module odd_even_transposition_sorter_core #(
  parameter int DEPTH = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire oets_pkg::item_t item,
  output logic                 busy,
  output logic                 valid,
  output oets_pkg::result_t    result
);

  oets_pkg::cmd_t front_cmd;
  oets_pkg::cmd_t back_cmd;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;

  assign busy = full;

  oets_front #(.DEPTH(DEPTH)) u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .full  (full),
    .push  (push),
    .cmd   (front_cmd)
  );

  oets_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_cmd),
    .pop   (pop),
    .rdata (back_cmd),
    .full  (full),
    .empty (empty)
  );

  oets_back #(.DEPTH(DEPTH)) u_back (
    .clk    (clk),
    .rst    (rst),
    .cmd    (back_cmd),
    .empty  (empty),
    .pop    (pop),
    .valid  (valid),
    .result (result)
  );

endmodule

`default_nettype wire

[design/oets_checker.sv]
// Port-level checks on the sorter's result stream, bound to the top level.
// Depends on oets_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module oets_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              valid,
  input wire oets_pkg::result_t result
);

  logic mid_batch;

  assign mid_batch = valid && !result.out_last;

  // Reset leaves no result in flight.
  `ASSERT_NEXT_ALWAYS(a_no_result_after_reset, rst, !valid)

  // A batch leaves without gaps until its final value.
  `ASSERT_NEXT(a_batch_contiguous, mid_batch, valid)

  // The overflow mark is the same on every result of a batch.
  `ASSERT_NEXT(a_overflow_steady, mid_batch, result.overflow == $past(result.overflow))

  // Values of one batch leave in ascending order.
  `ASSERT_NEXT(a_ascending, mid_batch, result.out_value >= $past(result.out_value))

endmodule

bind odd_even_transposition_sorter_core oets_checker u_oets_checker (
  .clk    (clk),
  .rst    (rst),
  .valid  (valid),
  .result (result)
);

`default_nettype wire

[test/sort_checker.sv]
`timescale 1ns / 100ps
// Checker for the odd-even transposition sorter: watches item transfers and result
// strobes, predicts the sorted output of each batch and compares it with what arrives.
// Depends on oets_pkg for the item and result types.
module sort_checker #(
  parameter int DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  oets_pkg::item_t   item,
  input  logic              valid,
  input  oets_pkg::result_t result,
  output int                errors,
  output int                pending,
  output int                compared
);

  logic signed [31:0] batch_vals[$];
  logic               batch_dropped;
  oets_pkg::result_t  sorted_q[$];

  always @(posedge clk) begin
    oets_pkg::result_t  want;
    logic signed [31:0] ordered[$];
    int                 j;
    if (rst) begin
      batch_vals.delete();
      sorted_q.delete();
      batch_dropped = 1'b0;
    end else begin
      // A result always belongs to a batch closed at an earlier transfer, so
      // results are checked before this edge's item is taken in.
      if (valid) begin
        compared++;
        if (sorted_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected result value %0d last %0b overflow %0b", $time,
                     result.out_value, result.out_last, result.overflow);
          end
        end else begin
          want = sorted_q.pop_front();
          if (result.out_value !== want.out_value || result.out_last !== want.out_last ||
              result.overflow !== want.overflow) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: want value %0d last %0b ovf %0b, got value %0d last %0b ovf %0b",
                       $time, want.out_value, want.out_last, want.overflow,
                       result.out_value, result.out_last, result.overflow);
            end
          end
        end
      end
      if (start && !busy) begin
        if (batch_vals.size() < DEPTH) begin
          batch_vals.push_back(item.in_value);
        end else begin
          batch_dropped = 1'b1;
        end
        if (item.is_last) begin
          ordered.delete();
          foreach (batch_vals[k]) begin
            j = 0;
            while (j < ordered.size() && ordered[j] <= batch_vals[k]) j++;
            ordered.insert(j, batch_vals[k]);
          end
          foreach (ordered[k]) begin
            want.out_value = ordered[k];
            want.out_last  = (k == ordered.size() - 1);
            want.overflow  = batch_dropped;
            sorted_q.push_back(want);
          end
          batch_vals.delete();
          batch_dropped = 1'b0;
        end
      end
    end
    pending <= sorted_q.size();
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// Top of the sorter testbench: clock, reset, batches of values to sort and the verdict.
// Depends on oets_pkg, sort_checker and odd_even_transposition_sorter_core.
module tb_top;

  localparam int DEPTH        = 32;
  localparam int ITEM_TARGET  = 110;
  localparam int DRAIN_LIMIT  = 20000;
  localparam logic signed [31:0] VMIN = 32'sh8000_0000;
  localparam logic signed [31:0] VMAX = 32'sh7fff_ffff;

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  oets_pkg::item_t   item;
  logic              busy;
  logic              valid;
  oets_pkg::result_t result;

  int errors;
  int pending;
  int compared;
  int items_sent = 0;
  int batches_sent = 0;
  int full_batches = 0;
  int overflow_batches = 0;

  always #5 clk = ~clk;

  odd_even_transposition_sorter_core #(.DEPTH(DEPTH)) u_dut (
    .clk, .rst, .start, .item, .busy, .valid, .result
  );

  sort_checker #(.DEPTH(DEPTH)) u_checker (
    .clk, .rst, .start, .busy, .item, .valid, .result, .errors, .pending, .compared
  );

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic signed [31:0] pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) begin
      case ($urandom_range(4))
        0: return VMIN;
        1: return VMAX;
        2: return 0;
        3: return -1;
        default: return 1;
      endcase
    end else if (roll < 35) begin
      // A narrow range makes equal values common.
      return int'($urandom_range(16)) - 8;
    end
    return $urandom;
  endfunction

  // One transfer; the sender may idle first, except in a quiet stretch of items.
  task automatic send_item(input logic signed [31:0] v, input logic l);
    logic quiet;
    quiet = (items_sent >= 40 && items_sent < 80);
    if (!quiet && $urandom_range(99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item  <= '{in_value: v, is_last: l};
    start <= 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
    if (l) batches_sent++;
  endtask

  task automatic send_batch(input int count);
    for (int i = 0; i < count; i++) send_item(pick_value(), i == count - 1);
    if (count > DEPTH) overflow_batches++;
    else if (count == DEPTH) full_batches++;
  endtask

  // Holds the sender off until every sorted value owed has come out.
  task automatic settle();
    int waited;
    waited = 0;
    start <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
  endtask

  initial begin
    int roll;
    rst   <= 1'b1;
    start <= 1'b0;
    item  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Single-value batch, extremes with repeats, reverse order, all equal, in order.
    send_item(VMAX, 1'b1);
    send_item(VMIN, 1'b0);
    send_item(VMAX, 1'b0);
    send_item(-1, 1'b0);
    send_item(0, 1'b0);
    send_item(1, 1'b0);
    send_item(VMIN, 1'b0);
    send_item(VMAX, 1'b1);
    for (int i = 5; i >= 1; i--) send_item(i, i == 1);
    for (int i = 0; i < 3; i++) send_item(7, i == 2);
    send_item(-5, 1'b0);
    send_item(5, 1'b1);
    settle();

    // A batch that exactly fills the store, then one that overflows it.
    send_batch(DEPTH);
    send_batch(DEPTH + $urandom_range(1, 8));
    while (items_sent < ITEM_TARGET) begin
      roll = $urandom_range(99);
      if (roll < 80) send_batch($urandom_range(1, 8));
      else if (roll < 94) send_batch($urandom_range(9, DEPTH - 1));
      else if (roll < 97) send_batch(DEPTH);
      else send_batch($urandom_range(DEPTH + 1, DEPTH + 6));
      if ($urandom_range(19) == 0) settle();
    end

    settle();
    repeat (200) @(posedge clk);
    $display("Sorted %0d batches from %0d items; %0d filled the store, %0d overflowed it.",
             batches_sent, items_sent, full_batches, overflow_batches);
    $display("%0d sorted values checked, %0d mismatches.", compared, errors);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
